// File: rtl/core/wses_pkg.sv
// Shared types and constants for the weekly schedule edge-event block.
// Used by wses_ctrl, wses_dp and weekly_schedule_edge_events; no dependencies.
package wses_pkg;

  localparam int SCHEDULES    = 8;
  localparam int SCHED_W      = 3;
  localparam int SLOT_W       = SCHED_W + 1;
  localparam int CNT_W        = 4;
  localparam int MINUTE_W     = 14;
  localparam int HOUR_MINUTES = 60;
  localparam int DAY_MINUTES  = 24 * 60;
  localparam int WEEK_MINUTES = 7 * DAY_MINUTES;
  localparam int VAR_W        = 16;
  localparam int TYPE_W       = 6;
  localparam int VALUE_W      = 64;
  localparam int FUNC_W       = 3;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 8;

  typedef enum logic [FUNC_W-1:0] {
    FN_TICK     = 3'd0,
    FN_WR_BIT   = 3'd1,
    FN_WR_VAR   = 3'd2,
    FN_WR_TYPE  = 3'd3,
    FN_WR_VALUE = 3'd4,
    FN_RESTART  = 3'd5
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COUNT   = 2'd0,
    CFG_ENABLE  = 2'd1,
    CFG_RUNNING = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_NONE = 2'd0,
    ST_OFF  = 2'd1,
    ST_ON   = 2'd2
  } sched_st_e;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EVAL = 3'b010,
    S_EMIT = 3'b100
  } ctrl_st_e;

  // controller -> datapath
  typedef struct packed {
    logic accept;  // input request taken this cycle
    logic eval;    // bitmap word is ready, compare against tracked states
    logic pop;     // current event taken by the consumer
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic tick_go;   // request at the input is a tick that must be worked
    logic emit_any;  // evaluation produced at least one event
    logic last;      // one pending event left
  } sts_t;

endpackage

// File: rtl/core/weekly_schedule_edge_events.sv
// Top level of the weekly schedule edge-event block.
// Depends on wses_pkg, wses_ctrl and wses_dp.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+---------------------------------------
//  cfg      | cfg_valid_i/cfg_ready_o  | cfg_index_i, cfg_data_i
//  in       | in_valid_i/in_ready_o    | func_i .. action_value_i
//  out      | out_valid_o/out_ready_i  | schedule_index_o .. last_o
//
// Write and restart requests finish when taken. A tick reads the bitmap into
// a register, then compares states, then sends one event per cycle while
// out_ready_i is high. Input is held off until the last event of a tick is
// taken. Reset is asynchronous; the bitmap is not cleared. Config writes are
// always ready.
module weekly_schedule_edge_events (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [wses_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [wses_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [wses_pkg::FUNC_W-1:0]         func_i,
  input  logic [wses_pkg::MINUTE_W-1:0]       minute_index_i,
  input  logic [wses_pkg::SCHED_W-1:0]        schedule_i,
  input  logic [2:0]                          day_of_week_i,
  input  logic [4:0]                          hour_i,
  input  logic [5:0]                          minute_i,
  input  logic                                bit_value_i,
  input  logic                                edge_req_i,
  input  logic [wses_pkg::VAR_W-1:0]          variable_id_i,
  input  logic [wses_pkg::TYPE_W-1:0]         value_type_i,
  input  logic [wses_pkg::VALUE_W-1:0]        action_value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [wses_pkg::SCHED_W-1:0]        schedule_index_o,
  output logic                                edge_kind_o,
  output logic [wses_pkg::VAR_W-1:0]          event_variable_o,
  output logic [wses_pkg::TYPE_W-1:0]         event_type_o,
  output logic [wses_pkg::VALUE_W-1:0]        event_value_o,
  output logic                                last_o
);

  wses_pkg::cmd_t cmd;
  wses_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  wses_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  wses_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .func_i           (func_i),
    .minute_index_i   (minute_index_i),
    .schedule_i       (schedule_i),
    .day_of_week_i    (day_of_week_i),
    .hour_i           (hour_i),
    .minute_i         (minute_i),
    .bit_value_i      (bit_value_i),
    .edge_req_i       (edge_req_i),
    .variable_id_i    (variable_id_i),
    .value_type_i     (value_type_i),
    .action_value_i   (action_value_i),
    .schedule_index_o (schedule_index_o),
    .edge_kind_o      (edge_kind_o),
    .event_variable_o (event_variable_o),
    .event_type_o     (event_type_o),
    .event_value_o    (event_value_o),
    .last_o           (last_o)
  );

endmodule

// File: rtl/core/wses_ctrl.sv
// Sequencer for the weekly schedule block: idle, evaluate, emit.
// Depends on wses_pkg; drives the command struct into wses_dp.
module wses_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  wses_pkg::sts_t sts_i,
  output wses_pkg::cmd_t cmd_o
);

  wses_pkg::ctrl_st_e state_q, state_d;

  assign in_ready_o  = (state_q == wses_pkg::S_IDLE);
  assign out_valid_o = (state_q == wses_pkg::S_EMIT);

  assign cmd_o.accept = in_valid_i && in_ready_o;
  assign cmd_o.eval   = (state_q == wses_pkg::S_EVAL);
  assign cmd_o.pop    = out_valid_o && out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      wses_pkg::S_IDLE: begin
        if (cmd_o.accept && sts_i.tick_go) state_d = wses_pkg::S_EVAL;
      end
      wses_pkg::S_EVAL: begin
        state_d = sts_i.emit_any ? wses_pkg::S_EMIT : wses_pkg::S_IDLE;
      end
      wses_pkg::S_EMIT: begin
        if (cmd_o.pop && sts_i.last) state_d = wses_pkg::S_IDLE;
      end
      default: state_d = wses_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wses_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("controller state not one-hot");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.pop && sts_i.last) |=> (state_q == wses_pkg::S_IDLE))
    else $error("tick did not end after last event");

  a_plain_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.accept && !sts_i.tick_go) |=> (state_q == wses_pkg::S_IDLE))
    else $error("non-tick request left idle");

  a_eval_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == wses_pkg::S_EVAL) |=> (state_q != wses_pkg::S_EVAL))
    else $error("evaluation lasted more than one cycle");

endmodule

// File: rtl/core/wses_dp.sv
// Datapath: config registers, week bitmap memory, action stores, schedule
// state tracking and the pending event mask. Depends on wses_pkg.
module wses_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  wses_pkg::cmd_t                      cmd_i,
  output wses_pkg::sts_t                      sts_o,
  input  logic                                cfg_valid_i,
  input  logic [wses_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [wses_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic [wses_pkg::FUNC_W-1:0]         func_i,
  input  logic [wses_pkg::MINUTE_W-1:0]       minute_index_i,
  input  logic [wses_pkg::SCHED_W-1:0]        schedule_i,
  input  logic [2:0]                          day_of_week_i,
  input  logic [4:0]                          hour_i,
  input  logic [5:0]                          minute_i,
  input  logic                                bit_value_i,
  input  logic                                edge_req_i,
  input  logic [wses_pkg::VAR_W-1:0]          variable_id_i,
  input  logic [wses_pkg::TYPE_W-1:0]         value_type_i,
  input  logic [wses_pkg::VALUE_W-1:0]        action_value_i,
  output logic [wses_pkg::SCHED_W-1:0]        schedule_index_o,
  output logic                                edge_kind_o,
  output logic [wses_pkg::VAR_W-1:0]          event_variable_o,
  output logic [wses_pkg::TYPE_W-1:0]         event_type_o,
  output logic [wses_pkg::VALUE_W-1:0]        event_value_o,
  output logic                                last_o
);

  localparam int NS = wses_pkg::SCHEDULES;
  localparam int NSLOT = 2 * wses_pkg::SCHEDULES;

  // configuration
  logic [wses_pkg::CNT_W-1:0] count_q;
  logic [NS-1:0]              enable_q;
  logic                       running_q;

  // storage
  logic [NS-1:0]                  bitmap [wses_pkg::WEEK_MINUTES];
  logic [NS-1:0]                  rd_q;
  logic                           in_week_q;
  logic [wses_pkg::VAR_W-1:0]     var_q   [NSLOT];
  logic [wses_pkg::TYPE_W-1:0]    type_q  [NSLOT];
  logic [wses_pkg::VALUE_W-1:0]   value_q [NSLOT];
  wses_pkg::sched_st_e            st_q    [NS];
  logic [wses_pkg::MINUTE_W-1:0]  last_tick_q;
  logic [NS-1:0]                  pend_q;

  logic [wses_pkg::CNT_W-1:0]     used_cnt;
  logic                           sched_ok;
  logic [wses_pkg::MINUTE_W-1:0]  lin;
  logic                           lin_ok;
  logic                           idx_ok;
  logic [NS-1:0]                  bits;
  logic [NS-1:0]                  active;
  logic [NS-1:0]                  emit;
  logic [wses_pkg::SCHED_W-1:0]   cur;
  logic [wses_pkg::SLOT_W-1:0]    wr_slot;
  logic [wses_pkg::SLOT_W-1:0]    rd_slot;
  logic                           cur_edge;

  assign used_cnt = (count_q > wses_pkg::CNT_W'(NS)) ? wses_pkg::CNT_W'(NS) : count_q;
  assign sched_ok = (wses_pkg::CNT_W'(schedule_i) < used_cnt);
  assign wr_slot  = {edge_req_i, schedule_i};

  assign lin = wses_pkg::MINUTE_W'(day_of_week_i)
                 * wses_pkg::MINUTE_W'(wses_pkg::DAY_MINUTES)
             + wses_pkg::MINUTE_W'(hour_i) * wses_pkg::MINUTE_W'(wses_pkg::HOUR_MINUTES)
             + wses_pkg::MINUTE_W'(minute_i);
  assign lin_ok = (lin < wses_pkg::MINUTE_W'(wses_pkg::WEEK_MINUTES));
  assign idx_ok = (minute_index_i < wses_pkg::MINUTE_W'(wses_pkg::WEEK_MINUTES));

  assign sts_o.tick_go = (func_i == wses_pkg::FN_TICK) && running_q
                         && (minute_index_i != last_tick_q);

  // out-of-week ticks see every schedule as off
  assign bits = in_week_q ? rd_q : '0;

  always_comb begin
    for (int i = 0; i < NS; i++) begin
      active[i] = enable_q[i] && (wses_pkg::CNT_W'(i) < used_cnt);
      emit[i]   = active[i]
                  && (st_q[i] != (bits[i] ? wses_pkg::ST_ON : wses_pkg::ST_OFF))
                  && (var_q[{~bits[i], wses_pkg::SCHED_W'(i)}] != '0);
    end
  end

  assign sts_o.emit_any = |emit;
  assign sts_o.last     = ((pend_q & (pend_q - NS'(1))) == '0);

  // lowest pending schedule goes out first
  always_comb begin
    cur = '0;
    for (int i = NS - 1; i >= 0; i--) begin
      if (pend_q[i]) cur = wses_pkg::SCHED_W'(i);
    end
  end

  assign cur_edge = ~bits[cur];
  assign rd_slot  = {cur_edge, cur};

  assign schedule_index_o = cur;
  assign edge_kind_o      = cur_edge;
  assign event_variable_o = var_q[rd_slot];
  assign event_type_o     = type_q[rd_slot];
  assign event_value_o    = value_q[rd_slot];
  assign last_o           = sts_o.last;

  // week bitmap: bit write and registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && (func_i == wses_pkg::FN_WR_BIT) && sched_ok && lin_ok) begin
      bitmap[lin][schedule_i] <= bit_value_i;
    end
    if (cmd_i.accept && sts_o.tick_go && idx_ok) begin
      rd_q <= bitmap[minute_index_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      enable_q  <= '0;
      running_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        wses_pkg::CFG_COUNT:   count_q   <= cfg_data_i[wses_pkg::CNT_W-1:0];
        wses_pkg::CFG_ENABLE:  enable_q  <= cfg_data_i[NS-1:0];
        wses_pkg::CFG_RUNNING: running_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NSLOT; s++) begin
        var_q[s]   <= '0;
        type_q[s]  <= '0;
        value_q[s] <= '0;
      end
    end else if (cmd_i.accept && sched_ok) begin
      if (func_i == wses_pkg::FN_WR_VAR)   var_q[wr_slot]   <= variable_id_i;
      if (func_i == wses_pkg::FN_WR_TYPE)  type_q[wr_slot]  <= value_type_i;
      if (func_i == wses_pkg::FN_WR_VALUE) value_q[wr_slot] <= action_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NS; i++) st_q[i] <= wses_pkg::ST_NONE;
      last_tick_q <= '1;
      in_week_q   <= 1'b0;
      pend_q      <= '0;
    end else begin
      if (cmd_i.accept && (func_i == wses_pkg::FN_RESTART)) begin
        for (int i = 0; i < NS; i++) st_q[i] <= wses_pkg::ST_NONE;
        last_tick_q <= '1;
      end
      if (cmd_i.accept && sts_o.tick_go) begin
        last_tick_q <= minute_index_i;
        in_week_q   <= idx_ok;
      end
      if (cmd_i.eval) begin
        for (int i = 0; i < NS; i++) begin
          if (active[i]) st_q[i] <= bits[i] ? wses_pkg::ST_ON : wses_pkg::ST_OFF;
        end
        pend_q <= emit;
      end else if (cmd_i.pop) begin
        pend_q[cur] <= 1'b0;
      end
    end
  end

  a_pop_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> (pend_q != '0))
    else $error("event taken with nothing pending");

  a_event_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> (event_variable_o != '0))
    else $error("event with zero variable id");

  a_pop_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |=> ($countones(pend_q) == $countones($past(pend_q)) - 1))
    else $error("pending mask did not drop one event");

endmodule

// File: dv/tb_weekly_schedule_edge_events.sv
// Testbench for weekly_schedule_edge_events: directed and random requests
// checked against a scoreboard class that predicts every edge event.
// Depends on wses_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_weekly_schedule_edge_events;

  localparam int HOLD_CYCLES   = 300;
  localparam int STALL_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 12;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 37;
  localparam int HOME_MINUTES  = 16;
  localparam int MINUTE_MAX    = (1 << wses_pkg::MINUTE_W) - 1;

  localparam logic [wses_pkg::CFG_IDX_W-1:0] CFG_SPARE  = 2'd3;
  localparam logic [wses_pkg::FUNC_W-1:0]    FN_SPARE_A = 3'd6;
  localparam logic [wses_pkg::FUNC_W-1:0]    FN_SPARE_B = 3'd7;

  typedef struct packed {
    logic [wses_pkg::FUNC_W-1:0]   func;
    logic [wses_pkg::MINUTE_W-1:0] minute_index;
    logic [wses_pkg::SCHED_W-1:0]  schedule;
    logic [2:0]                    day_of_week;
    logic [4:0]                    hour;
    logic [5:0]                    minute;
    logic                          bit_value;
    logic                          edge_req;
    logic [wses_pkg::VAR_W-1:0]    variable_id;
    logic [wses_pkg::TYPE_W-1:0]   value_type;
    logic [wses_pkg::VALUE_W-1:0]  action_value;
  } sched_req_t;

  typedef struct packed {
    logic [wses_pkg::SCHED_W-1:0] schedule_index;
    logic                         edge_kind;
    logic [wses_pkg::VAR_W-1:0]   event_variable;
    logic [wses_pkg::TYPE_W-1:0]  event_type;
    logic [wses_pkg::VALUE_W-1:0] event_value;
    logic                         last;
  } edge_event_t;

  class edge_event_board;
    logic [wses_pkg::SCHEDULES-1:0] week_bits [wses_pkg::WEEK_MINUTES];
    wses_pkg::sched_st_e            track [wses_pkg::SCHEDULES];
    logic [wses_pkg::MINUTE_W-1:0]  last_tick;
    logic [wses_pkg::VAR_W-1:0]     act_var [2*wses_pkg::SCHEDULES];
    logic [wses_pkg::TYPE_W-1:0]    act_type [2*wses_pkg::SCHEDULES];
    logic [wses_pkg::VALUE_W-1:0]   act_value [2*wses_pkg::SCHEDULES];
    logic [wses_pkg::CNT_W-1:0]     count;
    logic [wses_pkg::SCHEDULES-1:0] mask;
    logic                           running;
    edge_event_t                    pending_events [$];
    int                             errors;
    int                             checked;

    function new();
      foreach (week_bits[m]) week_bits[m] = '0;
      foreach (act_var[s]) begin
        act_var[s]   = '0;
        act_type[s]  = '0;
        act_value[s] = '0;
      end
      count   = '0;
      mask    = '0;
      running = 1'b0;
      errors  = 0;
      checked = 0;
      restart();
    endfunction

    function void restart();
      last_tick = '1;
      foreach (track[i]) track[i] = wses_pkg::ST_NONE;
    endfunction

    function int unsigned used_count();
      return (count > wses_pkg::SCHEDULES) ? wses_pkg::SCHEDULES : count;
    endfunction

    function void set_reg(logic [wses_pkg::CFG_IDX_W-1:0] idx,
                          logic [wses_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        wses_pkg::CFG_COUNT:   count = data[wses_pkg::CNT_W-1:0];
        wses_pkg::CFG_ENABLE:  mask = data;
        wses_pkg::CFG_RUNNING: running = data[0];
        default: ;
      endcase
    endfunction

    function void run_tick(logic [wses_pkg::MINUTE_W-1:0] idx);
      logic [wses_pkg::SCHEDULES-1:0] bits;
      wses_pkg::sched_st_e            now;
      logic [wses_pkg::SLOT_W-1:0]    slot;
      edge_event_t                    burst [$];
      edge_event_t                    ev;
      if (!running || idx == last_tick) return;
      // minutes past the end of the week read as all off
      bits = (idx < wses_pkg::WEEK_MINUTES) ? week_bits[idx] : '0;
      for (int i = 0; i < used_count(); i++) begin
        if (!mask[i]) continue;
        now = bits[i] ? wses_pkg::ST_ON : wses_pkg::ST_OFF;
        if (now == track[i]) continue;
        slot = {now == wses_pkg::ST_OFF, wses_pkg::SCHED_W'(i)};
        if (act_var[slot] != '0) begin
          ev.schedule_index = wses_pkg::SCHED_W'(i);
          ev.edge_kind      = (now == wses_pkg::ST_OFF);
          ev.event_variable = act_var[slot];
          ev.event_type     = act_type[slot];
          ev.event_value    = act_value[slot];
          ev.last           = 1'b0;
          burst.push_back(ev);
        end
        track[i] = now;
      end
      if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
      foreach (burst[k]) pending_events.push_back(burst[k]);
      last_tick = idx;
    endfunction

    function void note_request(sched_req_t r);
      logic [wses_pkg::SLOT_W-1:0] slot;
      int                          lin;
      bit                          writable;
      slot     = {r.edge_req, r.schedule};
      writable = r.schedule < used_count();
      lin      = r.day_of_week * wses_pkg::DAY_MINUTES
               + r.hour * wses_pkg::HOUR_MINUTES + r.minute;
      case (r.func)
        wses_pkg::FN_TICK:     run_tick(r.minute_index);
        wses_pkg::FN_WR_BIT: begin
          if (writable && lin < wses_pkg::WEEK_MINUTES)
            week_bits[lin][r.schedule] = r.bit_value;
        end
        wses_pkg::FN_WR_VAR:   if (writable) act_var[slot] = r.variable_id;
        wses_pkg::FN_WR_TYPE:  if (writable) act_type[slot] = r.value_type;
        wses_pkg::FN_WR_VALUE: if (writable) act_value[slot] = r.action_value;
        wses_pkg::FN_RESTART:  restart();
        default: ;
      endcase
    endfunction

    function string fmt_event(edge_event_t e);
      return $sformatf("sched %0d %s var %h type %h value %h last %0d", e.schedule_index,
                       e.edge_kind ? "off" : "on", e.event_variable, e.event_type,
                       e.event_value, e.last);
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      errors++;
    endtask

    task check_event(edge_event_t got);
      edge_event_t want;
      if (pending_events.size() == 0) begin
        report_mismatch({"unexpected event: ", fmt_event(got)});
        return;
      end
      want = pending_events.pop_front();
      checked++;
      if (got !== want)
        report_mismatch({"got ", fmt_event(got), " / expected ", fmt_event(want)});
    endtask
  endclass

  logic                            clk_i;
  logic                            rst_ni;
  logic                            cfg_valid_i;
  logic                            cfg_ready_o;
  logic [wses_pkg::CFG_IDX_W-1:0]  cfg_index_i;
  logic [wses_pkg::CFG_DATA_W-1:0] cfg_data_i;
  logic                            in_valid_i;
  logic                            in_ready_o;
  logic [wses_pkg::FUNC_W-1:0]     func_i;
  logic [wses_pkg::MINUTE_W-1:0]   minute_index_i;
  logic [wses_pkg::SCHED_W-1:0]    schedule_i;
  logic [2:0]                      day_of_week_i;
  logic [4:0]                      hour_i;
  logic [5:0]                      minute_i;
  logic                            bit_value_i;
  logic                            edge_req_i;
  logic [wses_pkg::VAR_W-1:0]      variable_id_i;
  logic [wses_pkg::TYPE_W-1:0]     value_type_i;
  logic [wses_pkg::VALUE_W-1:0]    action_value_i;
  logic                            out_valid_o;
  logic                            out_ready_i;
  logic [wses_pkg::SCHED_W-1:0]    schedule_index_o;
  logic                            edge_kind_o;
  logic [wses_pkg::VAR_W-1:0]      event_variable_o;
  logic [wses_pkg::TYPE_W-1:0]     event_type_o;
  logic [wses_pkg::VALUE_W-1:0]    event_value_o;
  logic                            last_o;

  weekly_schedule_edge_events i_dut (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .in_valid_i,
    .in_ready_o,
    .func_i,
    .minute_index_i,
    .schedule_i,
    .day_of_week_i,
    .hour_i,
    .minute_i,
    .bit_value_i,
    .edge_req_i,
    .variable_id_i,
    .value_type_i,
    .action_value_i,
    .out_valid_o,
    .out_ready_i,
    .schedule_index_o,
    .edge_kind_o,
    .event_variable_o,
    .event_type_o,
    .event_value_o,
    .last_o
  );

  edge_event_board board;
  int              home [HOME_MINUTES];
  int              hold_req = 0;
  bit              no_idle = 1'b0;
  int              n_items = 0;
  int              n_cfg = 0;
  int              idle_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // every field random; callers override what the request uses
  function automatic sched_req_t noise_req();
    sched_req_t r;
    r.func         = wses_pkg::FUNC_W'($urandom);
    r.minute_index = wses_pkg::MINUTE_W'($urandom);
    r.schedule     = wses_pkg::SCHED_W'($urandom);
    r.day_of_week  = 3'($urandom);
    r.hour         = 5'($urandom);
    r.minute       = 6'($urandom);
    r.bit_value    = 1'($urandom);
    r.edge_req     = 1'($urandom);
    r.variable_id  = wses_pkg::VAR_W'($urandom);
    r.value_type   = wses_pkg::TYPE_W'($urandom);
    r.action_value = {$urandom, $urandom};
    return r;
  endfunction

  function automatic sched_req_t code_req(logic [wses_pkg::FUNC_W-1:0] f);
    sched_req_t r;
    r      = noise_req();
    r.func = f;
    return r;
  endfunction

  function automatic sched_req_t tick_req(int m);
    sched_req_t r;
    r              = code_req(wses_pkg::FN_TICK);
    r.minute_index = wses_pkg::MINUTE_W'(m);
    return r;
  endfunction

  function automatic sched_req_t bit_req(int s, int d, int h, int mi, bit b);
    sched_req_t r;
    r             = code_req(wses_pkg::FN_WR_BIT);
    r.schedule    = wses_pkg::SCHED_W'(s);
    r.day_of_week = 3'(d);
    r.hour        = 5'(h);
    r.minute      = 6'(mi);
    r.bit_value   = b;
    return r;
  endfunction

  function automatic sched_req_t home_bit_req(int m, int s, bit b);
    return bit_req(s, m / wses_pkg::DAY_MINUTES,
                   (m % wses_pkg::DAY_MINUTES) / wses_pkg::HOUR_MINUTES,
                   m % wses_pkg::HOUR_MINUTES, b);
  endfunction

  function automatic sched_req_t action_req(logic [wses_pkg::FUNC_W-1:0] f, int s, bit e,
                                            logic [wses_pkg::VAR_W-1:0] v,
                                            logic [wses_pkg::TYPE_W-1:0] t,
                                            logic [wses_pkg::VALUE_W-1:0] val);
    sched_req_t r;
    r              = code_req(f);
    r.schedule     = wses_pkg::SCHED_W'(s);
    r.edge_req     = e;
    r.variable_id  = v;
    r.value_type   = t;
    r.action_value = val;
    return r;
  endfunction

  // ticks only read minutes whose eight bits were all written, or none at all
  function automatic int pick_tick_minute();
    int sel;
    sel = $urandom_range(99, 0);
    if (sel < 75) return home[$urandom_range(HOME_MINUTES - 1, 0)];
    if (sel < 90) return $urandom_range(MINUTE_MAX, wses_pkg::WEEK_MINUTES);
    return int'(board.last_tick);
  endfunction

  function automatic sched_req_t next_request();
    int                           sel;
    sched_req_t                   r;
    logic [wses_pkg::VAR_W-1:0]   v;
    logic [wses_pkg::VALUE_W-1:0] val;
    sel = $urandom_range(99, 0);
    v   = ($urandom_range(99, 0) < 15) ? '0 : wses_pkg::VAR_W'($urandom);
    case ($urandom_range(9, 0))
      0:       val = '1;
      1:       val = '0;
      default: val = {$urandom, $urandom};
    endcase
    if (sel < 38) begin
      r = tick_req(pick_tick_minute());
    end else if (sel < 62) begin
      r = home_bit_req(home[$urandom_range(HOME_MINUTES - 1, 0)], $urandom_range(7, 0),
                       1'($urandom));
    end else if (sel < 70) begin
      r = bit_req($urandom_range(7, 0), $urandom_range(7, 0), $urandom_range(31, 0),
                  $urandom_range(63, 0), 1'($urandom));
    end else if (sel < 92) begin
      r = action_req(wses_pkg::FUNC_W'($urandom_range(int'(wses_pkg::FN_WR_VALUE),
                                                      int'(wses_pkg::FN_WR_VAR))),
                     $urandom_range(7, 0), 1'($urandom), v,
                     wses_pkg::TYPE_W'($urandom), val);
    end else if (sel < 95) begin
      r = code_req(wses_pkg::FN_RESTART);
    end else if (sel < 97) begin
      r = code_req((sel == 95) ? FN_SPARE_A : FN_SPARE_B);
    end else begin
      r = noise_req();
      if (r.func == wses_pkg::FN_TICK) r = tick_req(pick_tick_minute());
    end
    return r;
  endfunction

  task automatic send_request(sched_req_t r);
    int gap;
    gap = no_idle ? 0 : $urandom_range(7, 0);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    func_i         <= r.func;
    minute_index_i <= r.minute_index;
    schedule_i     <= r.schedule;
    day_of_week_i  <= r.day_of_week;
    hour_i         <= r.hour;
    minute_i       <= r.minute;
    bit_value_i    <= r.bit_value;
    edge_req_i     <= r.edge_req;
    variable_id_i  <= r.variable_id;
    value_type_i   <= r.value_type;
    action_value_i <= r.action_value;
    @(posedge clk_i);
    while (in_ready_o !== 1'b1) @(posedge clk_i);
    board.note_request(r);
    n_items++;
  endtask

  // drops valid and waits on the clock before returning, so a following request may raise valid
  task automatic wait_for_events(int extra);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.pending_events.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic configure(logic [wses_pkg::CNT_W-1:0] cnt,
                           logic [wses_pkg::CFG_DATA_W-1:0] en, logic run);
    logic [wses_pkg::CFG_IDX_W-1:0]  idx [4];
    logic [wses_pkg::CFG_DATA_W-1:0] dat [4];
    idx = '{wses_pkg::CFG_COUNT, wses_pkg::CFG_ENABLE, wses_pkg::CFG_RUNNING, CFG_SPARE};
    dat = '{{4'($urandom), cnt}, en, {7'($urandom), run}, 8'($urandom)};
    cfg_valid_i <= 1'b1;
    for (int k = 0; k < 4; k++) begin
      cfg_index_i <= idx[k];
      cfg_data_i  <= dat[k];
      @(posedge clk_i);
      while (cfg_ready_o !== 1'b1) @(posedge clk_i);
      board.set_reg(idx[k], dat[k]);
      n_cfg++;
    end
    cfg_valid_i <= 1'b0;
  endtask

  // result side: random stall per event, or one long hold-off on request
  initial begin
    int          stall;
    edge_event_t got;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = no_idle ? 0 : $urandom_range(7, 0);
      if (hold_req > 0) begin
        stall    = hold_req;
        hold_req = 0;
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (out_valid_o !== 1'b1) @(posedge clk_i);
      got = '{schedule_index: schedule_index_o, edge_kind: edge_kind_o,
              event_variable: event_variable_o, event_type: event_type_o,
              event_value: event_value_o, last: last_o};
      board.check_event(got);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no request or event moved for %0d cycles", STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [wses_pkg::CNT_W-1:0]      ph_count [PHASES];
    logic [wses_pkg::CFG_DATA_W-1:0] ph_mask [PHASES];
    logic                            ph_run [PHASES];
    rst_ni         = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = '0;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    func_i         = '0;
    minute_index_i = '0;
    schedule_i     = '0;
    day_of_week_i  = '0;
    hour_i         = '0;
    minute_i       = '0;
    bit_value_i    = 1'b0;
    edge_req_i     = 1'b0;
    variable_id_i  = '0;
    value_type_i   = '0;
    action_value_i = '0;
    board = new();
    home = '{0, 1, 59, 60, 1439, 1440, 8191, wses_pkg::WEEK_MINUTES - 1,
             0, 0, 0, 0, 0, 0, 0, 0};
    for (int k = 8; k < HOME_MINUTES; k++)
      home[k] = $urandom_range(wses_pkg::WEEK_MINUTES - 1, 0);
    ph_count = '{4'd8, 4'd8, 4'd8, 4'd3, 4'd15, 4'd8, 4'd0, 4'($urandom)};
    ph_mask  = '{8'hFF, 8'($urandom), 8'hFF, 8'hFF, 8'($urandom), 8'hFF, 8'h5A,
                 8'($urandom)};
    ph_run   = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // fill every bit of the home minutes so ticks never read unwritten storage
    configure(4'd8, 8'hFF, 1'b0);
    foreach (home[k])
      for (int s = 0; s < wses_pkg::SCHEDULES; s++)
        send_request(home_bit_req(home[k], s, 1'($urandom)));

    wait_for_events(SETTLE_CYCLES);
    configure(4'd8, 8'hFF, 1'b1);
    // schedule 3 keeps a zero variable id on its on-edge: it changes state silently
    for (int s = 0; s < wses_pkg::SCHEDULES; s++)
      send_request(action_req(wses_pkg::FN_WR_VAR, s, 1'b0,
                              (s == 0) ? 16'hFFFF : (s == 3) ? 16'h0000 :
                              wses_pkg::VAR_W'(16'h0100 + s),
                              wses_pkg::TYPE_W'(s), wses_pkg::VALUE_W'(s)));
    send_request(action_req(wses_pkg::FN_WR_TYPE, 0, 1'b0, 16'h0, 6'h3F, '0));
    send_request(action_req(wses_pkg::FN_WR_VALUE, 0, 1'b0, 16'h0, 6'h0, '1));
    send_request(action_req(wses_pkg::FN_WR_VAR, 0, 1'b1, 16'h0001, 6'h0, '0));
    send_request(action_req(wses_pkg::FN_WR_VAR, 7, 1'b1, 16'h8000, 6'h0, '0));
    send_request(action_req(wses_pkg::FN_WR_VALUE, 7, 1'b1, 16'h0, 6'h0,
                            64'h8000_0000_0000_0001));
    send_request(tick_req(home[0]));
    send_request(tick_req(home[0]));
    send_request(tick_req(wses_pkg::WEEK_MINUTES - 1));
    send_request(tick_req(wses_pkg::WEEK_MINUTES));
    send_request(tick_req(MINUTE_MAX));
    send_request(code_req(wses_pkg::FN_RESTART));
    send_request(tick_req(MINUTE_MAX));
    send_request(tick_req(8191));
    send_request(bit_req(0, 7, 0, 0, 1'b1));
    send_request(bit_req(1, 0, 31, 63, 1'b1));
    send_request(code_req(FN_SPARE_A));
    send_request(code_req(FN_SPARE_B));
    wait_for_events(SETTLE_CYCLES);
    configure(4'd8, 8'hFF, 1'b0);
    send_request(tick_req(home[1]));

    for (int p = 0; p < PHASES; p++) begin
      wait_for_events(SETTLE_CYCLES);
      configure(ph_count[p], ph_mask[p], ph_run[p]);
      no_idle = (p == 3);
      // block stalls its input while the event side is held off
      if (p == 2) hold_req = HOLD_CYCLES;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ((p == 4 && k == 20) || $urandom_range(49, 0) == 0) wait_for_events(0);
        send_request(next_request());
      end
    end
    no_idle = 1'b0;
    wait_for_events(SETTLE_CYCLES);

    if (board.pending_events.size() != 0)
      board.report_mismatch($sformatf("%0d expected events never arrived",
                                      board.pending_events.size()));
    $display("Sent %0d requests and %0d register writes; %0d edge events compared.",
             n_items, n_cfg, board.checked);
    $display("Run spanned ticks in and past the week, repeats, restarts, stopped ticks, "
             , "counts up to 15 and masks from none to all.");
    if (board.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
